// ----- hw/rtl/mmlp_pkg.sv -----
package mmlp_pkg;

    localparam int NAME_CAPACITY = 1024;
    localparam int CNT_W         = $clog2(NAME_CAPACITY);
    localparam int WORD_W        = 64;
    localparam int NAME_LEN_W    = 10;

    // result kinds
    localparam logic [1:0] KIND_NAME      = 2'd0;
    localparam logic [1:0] KIND_RECORD    = 2'd1;
    localparam logic [1:0] KIND_MALFORMED = 2'd2;
    localparam logic [1:0] KIND_END       = 2'd3;

    // characters the syntax is built from
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_W      = 8'h77;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_P      = 8'h70;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            kind;
        logic [WORD_W-1:0]     start_addr;
        logic [WORD_W-1:0]     end_addr;
        logic [WORD_W-1:0]     file_offset;
        logic [WORD_W-1:0]     dev_major;
        logic [WORD_W-1:0]     dev_minor;
        logic [WORD_W-1:0]     inode_number;
        logic [2:0]            prot_bits;
        logic                  is_shared;
        logic                  is_anonymous;
        logic [7:0]            name_char;
        logic [NAME_LEN_W-1:0] name_length;
    } t_out_item;

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        res  = '0;
        diff = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            diff = c - 8'h30;
            res  = {1'b1, diff[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            diff = c - 8'h57;
            res  = {1'b1, diff[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            diff = c - 8'h37;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/mmlp_parser.sv -----
module mmlp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  mmlp_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output mmlp_pkg::t_out_item o_res
);
    import mmlp_pkg::*;

    localparam logic [3:0] PH_LINE    = 4'd0;
    localparam logic [3:0] PH_END     = 4'd1;
    localparam logic [3:0] PH_R       = 4'd2;
    localparam logic [3:0] PH_W       = 4'd3;
    localparam logic [3:0] PH_X       = 4'd4;
    localparam logic [3:0] PH_S       = 4'd5;
    localparam logic [3:0] PH_SP      = 4'd6;
    localparam logic [3:0] PH_OFF     = 4'd7;
    localparam logic [3:0] PH_MAJ     = 4'd8;
    localparam logic [3:0] PH_MIN     = 4'd9;
    localparam logic [3:0] PH_INODE   = 4'd10;
    localparam logic [3:0] PH_SPACES  = 4'd11;
    localparam logic [3:0] PH_NAME    = 4'd12;
    localparam logic [3:0] PH_DISCARD = 4'd13;

    logic [3:0]        r_phase, n_phase;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_start, n_start;
    logic [WORD_W-1:0] r_end, n_end;
    logic [WORD_W-1:0] r_off, n_off;
    logic [WORD_W-1:0] r_maj, n_maj;
    logic [WORD_W-1:0] r_min, n_min;
    logic [3:0]        r_perm, n_perm;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_digits, n_digits;

    logic [7:0]        c;
    logic              is_end;
    logic              is_nl;
    logic [4:0]        hv;
    logic              hex_ok;
    logic              dec_ok;
    logic [WORD_W-1:0] acc_hex;
    logic [WORD_W-1:0] acc_dec;
    logic              name_start;
    logic              name_full;
    logic              do_fail, do_rec, do_eos, do_name, do_restart;

    assign c          = i_item.char_in;
    assign is_end     = i_item.end_of_input || (c == CH_NUL);
    assign is_nl      = (c == CH_NL);
    assign hv         = hex_digit(c);
    assign hex_ok     = hv[4];
    assign dec_ok     = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc_hex    = {r_acc[WORD_W-5:0], hv[3:0]};
    assign acc_dec    = (r_acc << 3) + (r_acc << 1) + WORD_W'(c[3:0]);
    assign name_start = (c == CH_SLASH) || (c == CH_LBRACK) || (c == CH_LPAREN);
    assign name_full  = (r_cnt == CNT_W'(NAME_CAPACITY - 1));

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_start    = r_start;
        n_end      = r_end;
        n_off      = r_off;
        n_maj      = r_maj;
        n_min      = r_min;
        n_perm     = r_perm;
        n_cnt      = r_cnt;
        n_digits   = r_digits;
        do_fail    = 1'b0;
        do_rec     = 1'b0;
        do_eos     = 1'b0;
        do_name    = 1'b0;
        do_restart = 1'b0;

        if (r_phase == PH_DISCARD) begin
            // drop everything up to the newline or the end of input
            if (is_end) begin
                do_eos = 1'b1;
            end else if (is_nl) begin
                do_restart = 1'b1;
            end
        end else if (is_end) begin
            if (r_phase == PH_LINE && !r_digits) begin
                do_eos = 1'b1;
            end else begin
                do_fail = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_LINE: begin
                    if (hex_ok) begin
                        n_acc    = acc_hex;
                        n_digits = 1'b1;
                    end else if (c == CH_DASH) begin
                        n_start = r_acc;
                        n_acc   = '0;
                        n_phase = PH_END;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_END: begin
                    if (hex_ok) begin
                        n_acc = acc_hex;
                    end else if (c == CH_SPACE && r_acc >= r_start) begin
                        n_end   = r_acc;
                        n_acc   = '0;
                        n_phase = PH_R;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_R, PH_W, PH_X: begin
                    if (r_phase == PH_R && c == CH_R) begin
                        n_perm[0] = 1'b1;
                    end else if (r_phase == PH_W && c == CH_W) begin
                        n_perm[1] = 1'b1;
                    end else if (r_phase == PH_X && c == CH_X) begin
                        n_perm[2] = 1'b1;
                    end else if (c != CH_DASH) begin
                        do_fail = 1'b1;
                    end
                    n_phase = r_phase + 4'd1;
                end
                PH_S: begin
                    if (c == CH_S) begin
                        n_perm[3] = 1'b1;
                    end else if (c != CH_P) begin
                        do_fail = 1'b1;
                    end
                    n_phase = PH_SP;
                end
                PH_SP: begin
                    if (c == CH_SPACE) begin
                        n_acc   = '0;
                        n_phase = PH_OFF;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_OFF, PH_MAJ, PH_MIN: begin
                    if (hex_ok) begin
                        n_acc = acc_hex;
                    end else if (r_phase == PH_OFF && c == CH_SPACE) begin
                        n_off   = r_acc;
                        n_acc   = '0;
                        n_phase = PH_MAJ;
                    end else if (r_phase == PH_MAJ && c == CH_COLON) begin
                        n_maj   = r_acc;
                        n_acc   = '0;
                        n_phase = PH_MIN;
                    end else if (r_phase == PH_MIN && c == CH_SPACE) begin
                        n_min   = r_acc;
                        n_acc   = '0;
                        n_phase = PH_INODE;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                PH_INODE, PH_SPACES: begin
                    if (r_phase == PH_INODE && dec_ok) begin
                        n_acc = acc_dec;
                    end else begin
                        n_phase = PH_SPACES;
                        if (c == CH_SPACE) begin
                            n_phase = PH_SPACES;
                        end else if (name_start) begin
                            if (name_full) begin
                                do_fail = 1'b1;
                            end else begin
                                n_cnt   = r_cnt + CNT_W'(1);
                                n_phase = PH_NAME;
                                do_name = 1'b1;
                            end
                        end else if (is_nl) begin
                            do_rec = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                end
                PH_NAME: begin
                    if (is_nl) begin
                        do_rec = 1'b1;
                    end else if (name_full) begin
                        do_fail = 1'b1;
                    end else begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        do_name = 1'b1;
                    end
                end
                default: begin
                    do_restart = 1'b1;
                end
            endcase
        end

        // back to line start; a bad character mid-line starts a discard
        if (do_fail || do_rec || do_eos || do_restart) begin
            n_phase  = (do_fail && !is_end && !is_nl) ? PH_DISCARD : PH_LINE;
            n_acc    = '0;
            n_perm   = '0;
            n_cnt    = '0;
            n_digits = 1'b0;
        end
    end

    always_comb begin
        o_res       = '0;
        o_res_valid = do_fail || do_rec || do_eos || do_name;
        if (do_name) begin
            o_res.kind      = KIND_NAME;
            o_res.name_char = c;
        end else if (do_rec) begin
            o_res.kind         = KIND_RECORD;
            o_res.start_addr   = r_start;
            o_res.end_addr     = r_end;
            o_res.file_offset  = r_off;
            o_res.dev_major    = r_maj;
            o_res.dev_minor    = r_min;
            o_res.inode_number = r_acc;
            o_res.prot_bits    = r_perm[2:0];
            o_res.is_shared    = r_perm[3];
            o_res.is_anonymous = (r_cnt == '0);
            o_res.name_length  = NAME_LEN_W'(r_cnt);
        end else if (do_fail) begin
            o_res.kind = KIND_MALFORMED;
        end else if (do_eos) begin
            o_res.kind = KIND_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LINE;
            r_acc    <= '0;
            r_start  <= '0;
            r_end    <= '0;
            r_off    <= '0;
            r_maj    <= '0;
            r_min    <= '0;
            r_perm   <= '0;
            r_cnt    <= '0;
            r_digits <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_start  <= n_start;
            r_end    <= n_end;
            r_off    <= n_off;
            r_maj    <= n_maj;
            r_min    <= n_min;
            r_perm   <= n_perm;
            r_cnt    <= n_cnt;
            r_digits <= n_digits;
        end
    end

    a_cnt_only_in_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_phase == PH_NAME))
        else $error("name count live outside name phase");

    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISCARD) |-> (r_acc == '0 && r_perm == '0 && !r_digits))
        else $error("discard entered without line restart");

    a_eos_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && do_eos) |=> (r_phase == PH_LINE && r_acc == '0))
        else $error("end of input did not return to line start");

endmodule

// ----- hw/rtl/memory_map_line_parser.sv -----
// Flow: a character is held in the input register, and its result, if any,
//   is then loaded into the output register, from which the consumer takes it.
// Throughput: one character per cycle; a result held by a stalled consumer
//   holds the parse step, and the input stalls once the input register fills.
// Reset: synchronous, active low; the parser returns to line start with all
//   numbers cleared, and both the input and output registers empty.
module memory_map_line_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mmlp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mmlp_pkg::t_out_item o_out_item
);
    import mmlp_pkg::*;

    // input register: holds one character beat
    logic      r_in_valid;
    t_in_item  r_in_item;

    // output register: holds one result beat
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      fire;
    logic      in_accept;
    logic      res_valid;
    t_out_item res;

    // The parse step runs whenever a character is held and the output register can take a result.
    // While the consumer holds a result, every character waits, even one
    // that yields none.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    mmlp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Capture a new beat whenever the held one moves on (or none is held).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Load a result when free; hold it while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid && res_valid) begin
            r_out_item <= res;
        end
    end

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_no_step_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !fire)
        else $error("parse step taken while result is blocked");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("registers not empty after reset");

endmodule
